/* rtl/core/zxsc_pkg.sv */
// zxsc_pkg: shared constants for the zero-xor subarray counter
// no dependencies
package zxsc_pkg;
    localparam int BUCKETS_DEF    = 1024;
    localparam int KEY_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF = 32;
    localparam int WORD_BITS      = 32;
    localparam int TOTAL_BITS     = 63;
    localparam int QUEUE_DEPTH    = 2;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
endpackage

/* rtl/core/zxsc_front.sv */
// zxsc_front: accepts words, keeps the prefix xor, queues prefix values for the back end
// depends on zxsc_pkg
module zxsc_front
    import zxsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [WORD_BITS-1:0] in_word,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic [WORD_BITS-1:0] q_prefix
);
    logic [WORD_BITS-1:0] prefix_reg;
    logic [WORD_BITS-1:0] fifo_reg [QUEUE_DEPTH];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           cnt_reg;
    logic                 push;
    logic                 pop;
    logic [WORD_BITS-1:0] prefix_next;

    assign in_ready    = (cnt_reg != 2'd2);
    assign push        = in_valid && in_ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign pop         = q_valid && q_ready;
    assign q_prefix    = fifo_reg[rd_ptr_reg];
    assign prefix_next = prefix_reg ^ in_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                prefix_reg <= prefix_next;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= prefix_next;
    end
endmodule

/* rtl/core/zxsc_back.sv */
// zxsc_back: hash store probe, count update and running total
// depends on zxsc_pkg
module zxsc_back
    import zxsc_pkg::*;
#(
    parameter int BUCKETS    = BUCKETS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [WORD_BITS-1:0]  q_prefix,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TOTAL_BITS-1:0] out_total,
    output logic                  out_full
);
    localparam int IDX_BITS = $clog2(BUCKETS);
    localparam int KW = (KEY_BITS > WORD_BITS) ? KEY_BITS : WORD_BITS;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK, S_ADD, S_OUT} state_t;

    state_t                state_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [IDX_BITS:0]     probes_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic                  zero_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    logic                  full_reg;
    logic [COUNT_BITS-1:0] add_reg;
    logic                  out_valid_reg;
    logic [TOTAL_BITS-1:0] out_total_reg;
    logic                  out_full_reg;

    logic                  valid_mem [BUCKETS];
    logic [KEY_BITS-1:0]   key_mem   [BUCKETS];
    logic [COUNT_BITS-1:0] cnt_mem   [BUCKETS];
    logic                  rd_valid_reg;
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg;

    logic                  mem_we;
    logic [KEY_BITS-1:0]   mem_wkey;
    logic [COUNT_BITS-1:0] mem_wcnt;
    logic [KW-1:0]         key_wide;
    logic [KEY_BITS-1:0]   key_in;
    logic [TOTAL_BITS:0]   sum;
    logic [TOTAL_BITS-1:0] sat_sum;
    logic                  out_load;

    assign key_wide = KW'(q_prefix);
    assign key_in   = key_wide[KEY_BITS-1:0];
    assign q_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_total = out_total_reg;
    assign out_full  = out_full_reg;
    assign sum     = {1'b0, total_reg} + (TOTAL_BITS+1)'(add_reg) + (TOTAL_BITS+1)'(zero_reg);
    assign sat_sum = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
    // result register takes a new beat once the old one has left
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // write port: new entry with count one, or hit with incremented count
    always_comb
    begin
        mem_we   = 1'b0;
        mem_wkey = key_reg;
        mem_wcnt = '0;
        if (state_reg == S_CHECK)
        begin
            if (!rd_valid_reg)
            begin
                mem_we   = 1'b1;
                mem_wcnt = COUNT_BITS'(1);
            end
            else if (rd_key_reg == key_reg)
            begin
                mem_we   = 1'b1;
                mem_wcnt = (&rd_cnt_reg) ? rd_cnt_reg : rd_cnt_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR || mem_we)
            valid_mem[idx_reg] <= (state_reg != S_CLEAR);
        if (mem_we)
        begin
            key_mem[idx_reg] <= mem_wkey;
            cnt_mem[idx_reg] <= mem_wcnt;
        end
        rd_valid_reg <= valid_mem[idx_reg];
        rd_key_reg   <= key_mem[idx_reg];
        rd_cnt_reg   <= cnt_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            probes_reg    <= '0;
            key_reg       <= '0;
            zero_reg      <= 1'b0;
            total_reg     <= '0;
            full_reg      <= 1'b0;
            add_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_total_reg <= '0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_total_reg <= total_reg;
                out_full_reg  <= full_reg;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + IDX_BITS'(1);
                    if (idx_reg == IDX_BITS'(BUCKETS-1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        key_reg    <= key_in;
                        idx_reg    <= IDX_BITS'(key_in);
                        zero_reg   <= (q_prefix == '0);
                        probes_reg <= '0;
                        add_reg    <= '0;
                        state_reg  <= S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (mem_we)
                    begin
                        add_reg   <= rd_valid_reg ? rd_cnt_reg : '0;
                        state_reg <= S_ADD;
                    end
                    else if (probes_reg == (IDX_BITS+1)'(BUCKETS-1))
                    begin
                        full_reg  <= 1'b1;
                        state_reg <= S_ADD;
                    end
                    else
                    begin
                        idx_reg    <= idx_reg + IDX_BITS'(1);
                        probes_reg <= probes_reg + (IDX_BITS+1)'(1);
                        state_reg  <= S_READ;
                    end
                end
                S_ADD:
                begin
                    total_reg <= sat_sum;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/core/zero_xor_subarray_counter.sv */
// zero_xor_subarray_counter: top level, front end queue and hash store back end
// depends on zxsc_pkg, zxsc_front, zxsc_back
//
// channel  dir  handshake               payload
// s_axis   in   s_axis_tvalid/tready    tdata[31:0] word
// m_axis   out  m_axis_tvalid/tready    tdata[62:0] zero_xor_total, tuser table_full
//
// each word passes the back end read, check, add and output states, with a read and a check
// for each probe until a hit or free slot; a new word is taken only once the back end is idle,
// and the probe loop's single-port store read sets how soon that is
// after reset the store is cleared one entry a cycle, over all BUCKETS entries, while no word is taken
// a two-entry queue lets the input keep filling while a result waits
module zero_xor_subarray_counter
    import zxsc_pkg::*;
#(
    parameter int BUCKETS    = BUCKETS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // zero_xor_total, zero pad bit
    output logic        m_axis_tuser    // table_full
);
    logic                  q_valid;
    logic                  q_ready;
    logic [WORD_BITS-1:0]  q_prefix;
    logic [TOTAL_BITS-1:0] total;

    zxsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_word  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_prefix (q_prefix)
    );

    zxsc_back #(
        .BUCKETS    (BUCKETS),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_prefix  (q_prefix),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_total (total),
        .out_full  (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, total};
endmodule

/* rtl/core/zxsc_checker.sv */
// zxsc_checker: port-level checks for the zero-xor subarray counter
// depends on zero_xor_subarray_counter ports; bound to the top level
module zxsc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[63])
        else $error("pad bit set");

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(m_axis_tuser) |-> m_axis_tuser)
        else $error("full flag cleared");

    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> m_axis_tdata[62:0] >= $past(m_axis_tdata[62:0]))
        else $error("total decreased");

    // input ready only drops after a beat was taken
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && !s_axis_tvalid |=> s_axis_tready)
        else $error("input ready dropped without a beat");
endmodule

bind zero_xor_subarray_counter zxsc_checker u_zxsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
